/* hw/rtl/pcf_pkg.sv */
package pcf_pkg;

	// field widths of the framed stream
	localparam int TYPE_W      = 32;
	localparam int LEN_W       = 31;
	localparam int BYTE_W      = 8;
	localparam int STATUS_W    = 2;
	localparam int RUN_IDX_W   = 4;

	// defaults for the top level parameters
	localparam int LENGTH_BITS_DEF = 31;
	localparam int QUEUE_DEPTH_DEF = 4;

	// crc-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// input mode codes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROP    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABANDON = 2'd2;

	// command kinds between front and back
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_DROP  = 2'd2;

	// input word
	typedef struct packed {
		logic              mode;
		logic [TYPE_W-1:0] chunk_type;
		logic [LEN_W-1:0]  chunk_length;
		logic [BYTE_W-1:0] data_byte;
	} in_t;

	// output word
	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                run_last;
		logic                chunk_done;
		logic [STATUS_W-1:0] status;
	} out_t;

	// classified command: word holds the type on start, the byte on data
	typedef struct packed {
		logic [1:0]          kind;
		logic                close;
		logic [STATUS_W-1:0] status;
		logic [TYPE_W-1:0]   word;
		logic [LEN_W-1:0]    len;
	} cmd_t;

	// one byte of crc update, eight shift steps
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// big-endian byte select, sel 0 is the top byte
	function automatic logic [7:0] byte_of(logic [31:0] w, logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0:    r = w[31:24];
			2'd1:    r = w[23:16];
			2'd2:    r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/pcf_stream_if.sv */
interface pcf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pcf_front.sv */
module pcf_front #(
	parameter int LENGTH_BITS = pcf_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pcf_stream_if.sink        item,
	input  logic              full,
	output logic              push,
	output pcf_pkg::cmd_t     cmd
);

	logic                   open_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] len_m;
	logic                   last_data;

	// accept whenever the queue has room
	assign item.ready = !full;
	assign push       = item.valid && !full;

	assign len_m     = LENGTH_BITS'(item.data.chunk_length);
	assign last_data = (rem_q == LENGTH_BITS'(1));

	// classify the incoming word
	always_comb begin
		cmd.word = item.data.chunk_type;
		cmd.len  = pcf_pkg::LEN_W'(len_m);
		if (item.data.mode == pcf_pkg::MODE_START) begin
			cmd.kind   = pcf_pkg::KIND_START;
			cmd.close  = (len_m == '0);
			cmd.status = open_q ? pcf_pkg::ST_ABANDON : pcf_pkg::ST_OK;
		end else if (open_q) begin
			cmd.kind   = pcf_pkg::KIND_DATA;
			cmd.close  = last_data;
			cmd.status = pcf_pkg::ST_OK;
			cmd.word   = {24'd0, item.data.data_byte};
		end else begin
			cmd.kind   = pcf_pkg::KIND_DROP;
			cmd.close  = 1'b0;
			cmd.status = pcf_pkg::ST_DROP;
		end
	end

	// chunk tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= '0;
		end else if (push) begin
			if (item.data.mode == pcf_pkg::MODE_START) begin
				open_q <= (len_m != '0);
				rem_q  <= len_m;
			end else if (open_q) begin
				open_q <= !last_data;
				rem_q  <= rem_q - LENGTH_BITS'(1);
			end
		end
	end

endmodule

/* hw/rtl/pcf_queue.sv */
module pcf_queue #(
	parameter int DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output pcf_pkg::cmd_t head,
	output logic          head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pcf_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/pcf_back.sv */
module pcf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pcf_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	pcf_stream_if.source  stream
);

	logic [pcf_pkg::RUN_IDX_W-1:0] idx_q;
	logic [31:0]                   crc_q;
	pcf_pkg::out_t                 out_q;
	logic                          out_valid_q;

	logic                          advance;
	logic                          fire;
	logic                          is_last;
	logic                          upd;
	logic [31:0]                   base;
	logic [7:0]                    byte_n;
	logic                          done_n;
	logic [1:0]                    crc_sel;

	assign advance = !out_valid_q || stream.ready;
	assign fire    = head_valid && advance;
	assign pop     = fire && is_last;

	assign stream.valid = out_valid_q;
	assign stream.data  = out_q;

	// pick the byte of the current run step
	always_comb begin
		upd     = 1'b0;
		base    = crc_q;
		byte_n  = 8'd0;
		done_n  = 1'b0;
		is_last = 1'b1;
		crc_sel = idx_q[1:0];
		unique case (head.kind)
			pcf_pkg::KIND_START: begin
				is_last = head.close ? (idx_q == 4'd11) : (idx_q == 4'd7);
				if (idx_q < 4'd4) begin
					byte_n = pcf_pkg::byte_of({1'b0, head.len}, idx_q[1:0]);
				end else if (idx_q < 4'd8) begin
					byte_n = pcf_pkg::byte_of(head.word, idx_q[1:0]);
					upd    = 1'b1;
					base   = (idx_q == 4'd4) ? pcf_pkg::CRC_ONES : crc_q;
				end else begin
					byte_n = pcf_pkg::byte_of(~crc_q, idx_q[1:0]);
					done_n = (idx_q == 4'd11);
				end
			end
			pcf_pkg::KIND_DATA: begin
				is_last = head.close ? (idx_q == 4'd4) : (idx_q == 4'd0);
				crc_sel = idx_q[1:0] - 2'd1;
				if (idx_q == 4'd0) begin
					byte_n = head.word[7:0];
					upd    = 1'b1;
				end else begin
					byte_n = pcf_pkg::byte_of(~crc_q, crc_sel);
					done_n = (idx_q == 4'd4);
				end
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	// run step counter, crc and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= pcf_pkg::CRC_ONES;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			idx_q       <= is_last ? '0 : idx_q + 4'd1;
			out_valid_q <= 1'b1;
			if (upd) begin
				crc_q <= pcf_pkg::crc_byte(base, byte_n);
			end else if (done_n) begin
				crc_q <= pcf_pkg::CRC_ONES;
			end
		end else if (stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.out_byte   <= byte_n;
			out_q.run_last   <= is_last;
			out_q.chunk_done <= done_n;
			out_q.status     <= head.status;
		end
	end

endmodule

/* hw/rtl/png_chunk_framer_crc32.sv */
// channel  dir  payload                                       notes
// item     in   mode, chunk_type, chunk_length, data_byte     start or data byte
// stream   out  out_byte, run_last, chunk_done, status        one framed byte per word
//
// A data byte inside a chunk is a single command; one item can be accepted every cycle while the queue is not full.
// The back end emits one byte per cycle while the stream is ready: 8 for a start (12 for an empty chunk),
// 5 for the last data byte of a chunk, 1 otherwise; the byte emitter sets the rate.
// A queue of QUEUE_DEPTH commands lets input run ahead while long runs drain.
// Reset clears chunk tracking, the queue and the output register; no clearing pass.
// A stalled stream holds its word; the input stalls only when the queue is full.
module png_chunk_framer_crc32 #(
	parameter int LENGTH_BITS = pcf_pkg::LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pcf_stream_if.sink   item,
	pcf_stream_if.source stream
);

	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;
	pcf_pkg::cmd_t push_cmd;
	pcf_pkg::cmd_t head;

	// classify words and track the open chunk
	pcf_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// command queue between front and back
	pcf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// byte emitter with running crc
	pcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.stream     (stream)
	);

`ifndef NO_ASSERTIONS
	// the final crc byte always closes its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		stream.valid && stream.data.chunk_done |-> stream.data.run_last)
		else $error("chunk_done without run_last");

	// a dropped byte is a single zero word that closes no chunk
	a_drop_word: assert property (@(posedge clk) disable iff (!arst_n)
		stream.valid && (stream.data.status == pcf_pkg::ST_DROP) |->
		stream.data.run_last && !stream.data.chunk_done && (stream.data.out_byte == 8'd0))
		else $error("malformed drop word");

	// a queue pop only happens while a command is waiting
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

/* bench/tb_top.sv */
module tb_top;

	localparam int LEN_BITS = pcf_pkg::LENGTH_BITS_DEF;
	localparam logic [pcf_pkg::LEN_W-1:0] LEN_MASK =
		(LEN_BITS >= pcf_pkg::LEN_W) ? {pcf_pkg::LEN_W{1'b1}} :
		((31'd1 << LEN_BITS) - 31'd1);
	localparam int RANDOM_ITEMS = 470;
	localparam int IDLE_PCT     = 26;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 200;
	localparam int CALM_FROM    = 260;
	localparam int CALM_TO      = 360;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	pcf_stream_if #(.payload_t(pcf_pkg::in_t))  item_if ();
	pcf_stream_if #(.payload_t(pcf_pkg::out_t)) stream_if ();

	png_chunk_framer_crc32 #(
		.LENGTH_BITS(LEN_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.stream (stream_if)
	);

	// items waiting to be offered, framed bytes still owed by the block
	pcf_pkg::in_t  pending_items[$];
	pcf_pkg::out_t framed_bytes_due[$];
	pcf_pkg::out_t frame_run[$];

	int mismatches     = 0;
	int accepted_items = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	bit calm;

	// shadow chunk state
	logic [31:0]               crc_acc   = pcf_pkg::CRC_ONES;
	logic [pcf_pkg::LEN_W-1:0] data_left = '0;
	logic                      in_chunk  = 1'b0;

	assign calm = (accepted_items >= CALM_FROM) && (accepted_items < CALM_TO);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc_update(logic [31:0] acc, logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'd0, b};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ pcf_pkg::CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic emit(logic [7:0] b, logic done, logic [pcf_pkg::STATUS_W-1:0] st);
		pcf_pkg::out_t w;
		w.out_byte   = b;
		w.run_last   = 1'b0;
		w.chunk_done = done;
		w.status     = st;
		frame_run.push_back(w);
	endtask

	// four crc bytes big-endian, then the chunk is closed
	task automatic emit_crc(logic [pcf_pkg::STATUS_W-1:0] st);
		logic [31:0] v;
		v = crc_acc ^ pcf_pkg::CRC_ONES;
		for (int i = 0; i < 4; i++) begin
			emit(v[31-8*i -: 8], i == 3, st);
		end
		in_chunk  = 1'b0;
		data_left = '0;
		crc_acc   = pcf_pkg::CRC_ONES;
	endtask

	// expected words for one accepted item
	task automatic frame_item(pcf_pkg::in_t it);
		logic [pcf_pkg::STATUS_W-1:0] st;
		logic [31:0]                  len32;
		pcf_pkg::out_t                w;
		frame_run.delete();
		if (it.mode == pcf_pkg::MODE_START) begin
			st      = in_chunk ? pcf_pkg::ST_ABANDON : pcf_pkg::ST_OK;
			crc_acc = pcf_pkg::CRC_ONES;
			len32   = {1'b0, it.chunk_length & LEN_MASK};
			for (int i = 0; i < 4; i++) begin
				emit(len32[31-8*i -: 8], 1'b0, st);
			end
			for (int i = 0; i < 4; i++) begin
				crc_acc = crc_update(crc_acc, it.chunk_type[31-8*i -: 8]);
				emit(it.chunk_type[31-8*i -: 8], 1'b0, st);
			end
			if (len32 == 0) begin
				emit_crc(st);
			end else begin
				data_left = len32[pcf_pkg::LEN_W-1:0];
				in_chunk  = 1'b1;
			end
		end else if (!in_chunk) begin
			emit(8'h00, 1'b0, pcf_pkg::ST_DROP);
		end else begin
			crc_acc = crc_update(crc_acc, it.data_byte);
			emit(it.data_byte, 1'b0, pcf_pkg::ST_OK);
			data_left = (data_left - pcf_pkg::LEN_W'(1)) & LEN_MASK;
			if (data_left == 0) begin
				emit_crc(pcf_pkg::ST_OK);
			end
		end
		frame_run[frame_run.size()-1].run_last = 1'b1;
		foreach (frame_run[i]) begin
			w = frame_run[i];
			framed_bytes_due.push_back(w);
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic add_start(logic [31:0] typ, logic [pcf_pkg::LEN_W-1:0] len);
		pcf_pkg::in_t it;
		it.mode         = pcf_pkg::MODE_START;
		it.chunk_type   = typ;
		it.chunk_length = len;
		it.data_byte    = 8'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic add_data(logic [7:0] b);
		pcf_pkg::in_t it;
		it.mode         = pcf_pkg::MODE_DATA;
		it.chunk_type   = $urandom;
		it.chunk_length = pcf_pkg::LEN_W'($urandom);
		it.data_byte    = b;
		pending_items.push_back(it);
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else if (!item_if.valid || item_if.ready) begin
			if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				item_if.data  <= pending_items.pop_front();
				item_if.valid <= 1'b1;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// output back-pressure, one long hold-off to fill the block
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left       <= hold_left - 1;
			stream_if.ready <= 1'b0;
		end else if (!hold_done && accepted_items >= HOLD_AT) begin
			hold_done       <= 1'b1;
			hold_left       <= HOLD_CYCLES;
			stream_if.ready <= 1'b0;
		end else begin
			stream_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: predict on input words, check output words
	always @(posedge clk) begin : monitor
		pcf_pkg::out_t want;
		pcf_pkg::out_t got;
		if (arst_n) begin
			if (item_if.valid && item_if.ready) begin
				frame_item(item_if.data);
				accepted_items <= accepted_items + 1;
			end
			if (stream_if.valid && stream_if.ready) begin
				got = stream_if.data;
				if (framed_bytes_due.size() == 0) begin
					$error("unexpected word: out_byte %0h status %0d", got.out_byte, got.status);
					mismatches++;
				end else begin
					want = framed_bytes_due.pop_front();
					check_field("out_byte", want.out_byte, got.out_byte);
					check_field("run_last", 8'(want.run_last), 8'(got.run_last));
					check_field("chunk_done", 8'(want.chunk_done), 8'(got.chunk_done));
					check_field("status", 8'(want.status), 8'(got.status));
				end
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int total;
		int r;
		int len;
		int sent;
		// directed: drops, empty chunks, single byte, abandons, length extremes
		add_data(8'h00);
		add_start(32'hFFFF_FFFF, '0);
		add_start(32'h0000_0000, 31'd1);
		add_data(8'hFF);
		add_start(32'h4948_4452, 31'd3);
		add_data(8'h00);
		add_data(8'hA5);
		add_start(32'h4944_4154, 31'h7FFF_FFFF);
		add_data(8'h5A);
		add_start(32'h4945_4E44, '0);
		add_data(8'hFF);
		add_start(32'h7445_5874, 31'd2);
		add_data(8'h80);
		add_data(8'h01);
		add_start(32'h6162_6364, 31'h5555_5555);
		add_start(32'h5555_AAAA, 31'h2AAA_AAAA);
		add_start(32'h1234_5678, '0);
		total = pending_items.size() + RANDOM_ITEMS;

		// random: mostly whole chunks, some cut short, some stray bytes
		while (pending_items.size() < total) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = $urandom_range(12);
				add_start($urandom, pcf_pkg::LEN_W'(len));
				repeat (len) add_data(8'($urandom));
			end else if (r < 85) begin
				if ($urandom_range(2) == 0) begin
					add_start($urandom, pcf_pkg::LEN_W'($urandom));
					sent = $urandom_range(4);
				end else begin
					len = $urandom_range(2, 12);
					add_start($urandom, pcf_pkg::LEN_W'(len));
					sent = $urandom_range(len - 1);
				end
				repeat (sent) add_data(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 3)) add_data(8'($urandom));
			end
		end

		while (pending_items.size() != 0 || item_if.valid) @(negedge clk);
		while (framed_bytes_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_stream_if.sv
hw/rtl/pcf_front.sv
hw/rtl/pcf_queue.sv
hw/rtl/pcf_back.sv
hw/rtl/png_chunk_framer_crc32.sv
bench/tb_top.sv
